// ===== hw/rtl/tck_pkg.sv =====
`timescale 1ns / 1ps

package tck_pkg;

    localparam int ACTION_BITS  = 2;
    localparam int COUNT_BITS   = 2;
    localparam int ID_PORT_BITS = 32;

    // event kinds; the fourth code is unused and ignored
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_END   = 2'd2
    } t_action;

    // one event word presented to the slot logic
    typedef struct packed {
        logic    fire;
        t_action action;
    } t_step_ctl;

    // what the slot logic returns for that event
    typedef struct packed {
        logic                  emit;
        logic [COUNT_BITS-1:0] count;
        logic                  ever_used;
    } t_step_sts;

endpackage

// ===== hw/rtl/tck_evt_if.sv =====
`timescale 1ns / 1ps

interface tck_evt_if #(
    parameter int COORD_BITS = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [tck_pkg::ACTION_BITS-1:0]      action;
    logic [tck_pkg::ID_PORT_BITS-1:0]     contact_id;
    logic signed [COORD_BITS-1:0]         pos_x;
    logic signed [COORD_BITS-1:0]         pos_y;

    modport source (output valid, action, contact_id, pos_x, pos_y, input ready);
    modport sink   (input valid, action, contact_id, pos_x, pos_y, output ready);
endinterface

// ===== hw/rtl/tck_rpt_if.sv =====
`timescale 1ns / 1ps

interface tck_rpt_if #(
    parameter int COORD_BITS = 16
);
    logic                              valid;
    logic                              ready;
    logic [tck_pkg::COUNT_BITS-1:0]    touch_count;
    logic signed [COORD_BITS-1:0]      first_x;
    logic signed [COORD_BITS-1:0]      first_y;
    logic signed [COORD_BITS-1:0]      second_x;
    logic signed [COORD_BITS-1:0]      second_y;
    logic                              ever_used;

    modport source (output valid, touch_count, first_x, first_y, second_x, second_y,
                    ever_used, input ready);
    modport sink   (input valid, touch_count, first_x, first_y, second_x, second_y,
                    ever_used, output ready);
endinterface

// ===== hw/rtl/two_contact_touch_tracker.sv =====
`timescale 1ns / 1ps
// A result word passes through the event register, then the result register;
// an event waits in the event register while the result register is stalled.
// Throughput: one event word per cycle while the result register is empty or
// drained; the slot update is combinational logic between the event and result registers.
// Reset (i_rst_n low, synchronous): both slots empty, used flag clear,
// event and result registers empty.

module two_contact_touch_tracker #(
    parameter int COORD_BITS = 16,
    parameter int ID_BITS    = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tck_evt_if.sink      i_evt,
    tck_rpt_if.source    o_rpt
);

    // ---------------------------------------------------------------
    // Event register: holds one accepted word for the slot logic.
    // ---------------------------------------------------------------
    logic                             r_in_valid;
    logic [tck_pkg::ACTION_BITS-1:0]  r_in_action;
    logic [ID_BITS-1:0]               r_in_id;
    logic signed [COORD_BITS-1:0]     r_in_x;
    logic signed [COORD_BITS-1:0]     r_in_y;

    // ---------------------------------------------------------------
    // Result register: holds a finished word until the sink takes it;
    // while it waits, the event register can still absorb one word.
    // ---------------------------------------------------------------
    logic                             r_out_valid;
    logic [tck_pkg::COUNT_BITS-1:0]   r_out_count;
    logic signed [COORD_BITS-1:0]     r_out_fx, r_out_fy, r_out_sx, r_out_sy;
    logic                             r_out_used;

    logic                             advance;
    logic                             in_take;
    tck_pkg::t_step_ctl               step_ctl;
    tck_pkg::t_step_sts               step_sts;
    logic signed [COORD_BITS-1:0]     nxt_fx, nxt_fy, nxt_sx, nxt_sy;

    // the held event is processed when the result register can take
    // its word (empty, or drained this cycle)
    assign advance      = !r_out_valid || o_rpt.ready;
    assign i_evt.ready  = !r_in_valid || advance;
    assign in_take      = i_evt.valid && i_evt.ready;

    assign step_ctl.fire   = r_in_valid && advance;
    assign step_ctl.action = tck_pkg::t_action'(r_in_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // only the low ID_BITS of the contact id take part in matching
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_evt.action;
            r_in_id     <= i_evt.contact_id[ID_BITS-1:0];
            r_in_x      <= i_evt.pos_x;
            r_in_y      <= i_evt.pos_y;
        end
    end

    tck_slots #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (step_ctl),
        .i_id       (r_in_id),
        .i_x        (r_in_x),
        .i_y        (r_in_y),
        .o_sts      (step_sts),
        .o_first_x  (nxt_fx),
        .o_first_y  (nxt_fy),
        .o_second_x (nxt_sx),
        .o_second_y (nxt_sy)
    );

    // events that give no word (unmatched move/end, two-to-one end,
    // unused code) still consume their slot in the event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_ctl.fire) begin
            r_out_valid <= step_sts.emit;
        end else if (o_rpt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_ctl.fire && step_sts.emit) begin
            r_out_count <= step_sts.count;
            r_out_fx    <= nxt_fx;
            r_out_fy    <= nxt_fy;
            r_out_sx    <= nxt_sx;
            r_out_sy    <= nxt_sy;
            r_out_used  <= step_sts.ever_used;
        end
    end

    assign o_rpt.valid       = r_out_valid;
    assign o_rpt.touch_count = r_out_count;
    assign o_rpt.first_x     = r_out_fx;
    assign o_rpt.first_y     = r_out_fy;
    assign o_rpt.second_x    = r_out_sx;
    assign o_rpt.second_y    = r_out_sy;
    assign o_rpt.ever_used   = r_out_used;

endmodule

// ===== hw/rtl/tck_slots.sv =====
`timescale 1ns / 1ps

module tck_slots #(
    parameter int COORD_BITS = 16,
    parameter int ID_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tck_pkg::t_step_ctl           i_ctl,
    input  logic [ID_BITS-1:0]           i_id,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output tck_pkg::t_step_sts           o_sts,
    output logic signed [COORD_BITS-1:0] o_first_x,
    output logic signed [COORD_BITS-1:0] o_first_y,
    output logic signed [COORD_BITS-1:0] o_second_x,
    output logic signed [COORD_BITS-1:0] o_second_y
);

    logic                         r_a_v, n_a_v;
    logic [ID_BITS-1:0]           r_a_id, n_a_id;
    logic signed [COORD_BITS-1:0] r_a_x, n_a_x, r_a_y, n_a_y;
    logic                         r_b_v, n_b_v;
    logic [ID_BITS-1:0]           r_b_id, n_b_id;
    logic signed [COORD_BITS-1:0] r_b_x, n_b_x, r_b_y, n_b_y;
    logic                         r_seen, n_seen;
    logic                         id_eq_a, hit_a, hit_b, emit;

    assign id_eq_a = (i_id == r_a_id);
    assign hit_a   = r_a_v && id_eq_a;
    assign hit_b   = r_b_v && (i_id == r_b_id);

    always_comb begin
        n_a_v  = r_a_v;
        n_a_id = r_a_id;
        n_a_x  = r_a_x;
        n_a_y  = r_a_y;
        n_b_v  = r_b_v;
        n_b_id = r_b_id;
        n_b_x  = r_b_x;
        n_b_y  = r_b_y;
        n_seen = r_seen;
        emit   = 1'b0;
        if (i_ctl.fire) begin
            case (i_ctl.action)
                tck_pkg::ACT_BEGIN: begin
                    n_seen = 1'b1;
                    emit   = 1'b1;
                    if (!r_a_v) begin
                        n_a_v  = 1'b1;
                        n_a_id = i_id;
                        n_a_x  = i_x;
                        n_a_y  = i_y;
                    end else if (!r_b_v && !id_eq_a) begin
                        n_b_v  = 1'b1;
                        n_b_id = i_id;
                        n_b_x  = i_x;
                        n_b_y  = i_y;
                    end else if (hit_a) begin
                        n_a_x = i_x;
                        n_a_y = i_y;
                    end else if (hit_b) begin
                        n_b_x = i_x;
                        n_b_y = i_y;
                    end
                end
                tck_pkg::ACT_MOVE: begin
                    if (hit_a) begin
                        n_a_x = i_x;
                        n_a_y = i_y;
                        emit  = 1'b1;
                    end else if (hit_b) begin
                        n_b_x = i_x;
                        n_b_y = i_y;
                        emit  = 1'b1;
                    end
                end
                tck_pkg::ACT_END: begin
                    if (hit_a) begin
                        // B slides down into A when held
                        if (r_b_v) begin
                            n_a_id = r_b_id;
                            n_a_x  = r_b_x;
                            n_a_y  = r_b_y;
                            n_b_v  = 1'b0;
                        end else begin
                            n_a_v = 1'b0;
                            n_a_x = i_x;
                            n_a_y = i_y;
                        end
                        emit = !r_b_v;
                    end else if (hit_b) begin
                        n_b_v = 1'b0;
                        n_b_x = i_x;
                        n_b_y = i_y;
                        emit  = !r_a_v;
                    end
                end
                default: ;
            endcase
        end
    end

    // report is taken from the updated set
    always_comb begin
        o_first_x  = '0;
        o_first_y  = '0;
        o_second_x = '0;
        o_second_y = '0;
        case ({n_a_v, n_b_v})
            2'b11: begin
                o_first_x  = n_a_x;
                o_first_y  = n_a_y;
                o_second_x = n_b_x;
                o_second_y = n_b_y;
            end
            2'b10: begin
                o_first_x = n_a_x;
                o_first_y = n_a_y;
            end
            2'b01: begin
                o_first_x = n_b_x;
                o_first_y = n_b_y;
            end
            default: ;
        endcase
    end

    assign o_sts.emit      = emit;
    assign o_sts.count     = {n_a_v & n_b_v, n_a_v ^ n_b_v};
    assign o_sts.ever_used = n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            r_a_v  <= n_a_v;
            r_b_v  <= n_b_v;
            r_seen <= n_seen;
        end
    end

    // slot contents are only read while their valid bit is set
    always_ff @(posedge i_clk) begin
        r_a_id <= n_a_id;
        r_a_x  <= n_a_x;
        r_a_y  <= n_a_y;
        r_b_id <= n_b_id;
        r_b_x  <= n_b_x;
        r_b_y  <= n_b_y;
    end

endmodule

// ===== hw/rtl/tck_chk.sv =====
`timescale 1ns / 1ps

module tck_chk #(
    parameter int COORD_BITS = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tck_pkg::COUNT_BITS-1:0] i_count,
    input logic signed [COORD_BITS-1:0]   i_fx,
    input logic signed [COORD_BITS-1:0]   i_fy,
    input logic signed [COORD_BITS-1:0]   i_sx,
    input logic signed [COORD_BITS-1:0]   i_sy,
    input logic                           i_used
);

    logic r_used_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_used) begin
            r_used_seen <= 1'b1;
        end
    end

    // stalled word holds: valid, count and first x stay stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_count) && $stable(i_fx))
        else $error("result word dropped or changed under stall");

    // used flag is sticky once reported
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_used_seen |-> i_used)
        else $error("used flag fell after being reported");

    // a held contact means a begin was seen, and the count never reads three
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count != 2'd0 |-> i_used && i_count != 2'd3)
        else $error("contacts held without begin, or bad count");

    // positions beyond the count read as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count != 2'd2 |-> i_sx == '0 && i_sy == '0 &&
            (i_count != 2'd0 || (i_fx == '0 && i_fy == '0)))
        else $error("unused position not zero");

endmodule

bind two_contact_touch_tracker tck_chk #(
    .COORD_BITS (COORD_BITS)
) u_tck_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rpt.valid),
    .i_out_ready (o_rpt.ready),
    .i_count     (o_rpt.touch_count),
    .i_fx        (o_rpt.first_x),
    .i_fy        (o_rpt.first_y),
    .i_sx        (o_rpt.second_x),
    .i_sy        (o_rpt.second_y),
    .i_used      (o_rpt.ever_used)
);
